// File: design/slot_alloc_pkg.sv
// ----------------------------------------------------------------------------
// Slot allocator package
// Shared widths, defaults, opcode/status codes and sequencer states.
// ----------------------------------------------------------------------------
package slot_alloc_pkg;

   localparam int NUM_SLOTS_DEF = 16;
   localparam int ID_BITS_DEF   = 16;

   localparam int OPCODE_W   = 2;
   localparam int REL_ID_W   = 16;
   localparam int STATUS_W   = 2;
   localparam int SLOT_IDX_W = 4;
   localparam int GRANT_ID_W = 16;
   localparam int MAX_AGE_W  = 16;
   localparam int TIME_W     = 32;

   localparam logic [MAX_AGE_W-1:0] MAX_AGE_RST = 16'd1000;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_TICK    = 2'd2,
      OP_NOP     = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE      = 2'd0,
      STAT_NO_SLOT   = 2'd1,
      STAT_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } fsm_state_type;

endpackage

// File: design/slot_alloc_if.sv
// ----------------------------------------------------------------------------
// Slot allocator channels
// Request, response and control register write channels.
// ----------------------------------------------------------------------------
interface slot_alloc_req_if;
   logic                               valid;
   logic                               ready;
   logic [slot_alloc_pkg::OPCODE_W-1:0] opcode;
   logic [slot_alloc_pkg::REL_ID_W-1:0] release_id;

   modport source (output valid, output opcode, output release_id, input ready);
   modport sink   (input valid, input opcode, input release_id, output ready);
endinterface

interface slot_alloc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [slot_alloc_pkg::STATUS_W-1:0]   status;
   logic [slot_alloc_pkg::SLOT_IDX_W-1:0] slot_index;
   logic [slot_alloc_pkg::GRANT_ID_W-1:0] granted_id;
   logic                                 reclaimed;

   modport source (output valid, output status, output slot_index, output granted_id,
                   output reclaimed, input ready);
   modport sink   (input valid, input status, input slot_index, input granted_id,
                   input reclaimed, output ready);
endinterface

interface slot_alloc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [slot_alloc_pkg::MAX_AGE_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: design/slot_allocator_with_timeout_reclaim_top.sv
// ----------------------------------------------------------------------------
// Next-fit slot allocator with timeout reclaim
// Channels: req_chan takes one transaction per operation (allocate, release by
// id, tick, no-op); rsp_chan returns exactly one transaction per request;
// csr_chan writes max_age and is always ready (write only while idle).
// Throughput: one request at a time; req_chan.ready is high only while idle.
// Tick and no-op answer in the cycle after acceptance. Allocate and release scan
// the slot table one entry per cycle through the single read port of the
// owner/stamp RAM and examine 1..NUM_SLOTS slots before they respond.
// Allocate starts at the last granted slot and wraps; release starts at slot
// zero and frees the lowest matching busy slot.
// Reset: all slots free, time, id counter and search start at zero, max_age
// back to its default. The RAM needs no clearing pass; busy bits are flops.
// A stalled response is held in the output register; no new request is taken
// until it is delivered.
// ----------------------------------------------------------------------------
module slot_allocator_with_timeout_reclaim_top #(
   parameter int NUM_SLOTS = slot_alloc_pkg::NUM_SLOTS_DEF,
   parameter int ID_BITS   = slot_alloc_pkg::ID_BITS_DEF
) (
   input logic                clock,
   input logic                reset,
   slot_alloc_req_if.sink     req_chan,
   slot_alloc_rsp_if.source   rsp_chan,
   slot_alloc_csr_if.sink     csr_chan
);

   localparam int TIME_W    = slot_alloc_pkg::TIME_W;
   localparam int AGE_W     = slot_alloc_pkg::MAX_AGE_W;
   localparam int IDX_W     = slot_alloc_pkg::SLOT_IDX_W;
   localparam int GID_W     = slot_alloc_pkg::GRANT_ID_W;
   localparam int RID_W     = slot_alloc_pkg::REL_ID_W;
   localparam int SLOT_BITS = $clog2(NUM_SLOTS);
   localparam int CNT_BITS  = $clog2(NUM_SLOTS + 1);
   localparam int ENTRY_W   = ID_BITS + TIME_W;
   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(NUM_SLOTS - 1);
   localparam logic [CNT_BITS-1:0]  SCAN_LEN  = CNT_BITS'(NUM_SLOTS);
   localparam logic [CNT_BITS-1:0]  SCAN_LAST = CNT_BITS'(NUM_SLOTS - 1);

   slot_alloc_pkg::fsm_state_type state_ff, state_in;
   slot_alloc_pkg::opcode_type    op_ff, op_in, req_op;

   logic [NUM_SLOTS-1:0] busy_ff, busy_in;
   logic [TIME_W-1:0]    time_now_ff, time_now_in;
   logic [ID_BITS-1:0]   id_counter_ff, id_counter_in;
   logic [SLOT_BITS-1:0] search_start_ff, search_start_in;
   logic [AGE_W-1:0]     max_age_ff, max_age_in;
   logic [ID_BITS-1:0]   rid_ff, rid_in;
   logic [SLOT_BITS-1:0] scan_idx_ff, scan_idx_in;
   logic [CNT_BITS-1:0]  iss_cnt_ff, iss_cnt_in;
   logic                 pend_ff, pend_in;
   logic [SLOT_BITS-1:0] pend_idx_ff, pend_idx_in;
   logic                 pend_last_ff, pend_last_in;

   slot_alloc_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [GID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic                 rsp_recl_ff, rsp_recl_in;

   logic                 req_fire, rsp_fire, csr_fire;
   logic                 issue, cur_busy, timed_out, hit, scan_done;
   logic [TIME_W-1:0]    age;
   logic [ENTRY_W-1:0]   rd_entry, wr_entry;
   logic [ID_BITS-1:0]   rd_owner;
   logic [TIME_W-1:0]    rd_stamp;
   logic                 ram_we;
   logic [SLOT_BITS+IDX_W-1:0] slot_ext;
   logic [ID_BITS+GID_W-1:0]   gid_ext;
   logic [RID_W+ID_BITS-1:0]   rid_ext;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign csr_fire = csr_chan.valid && csr_chan.ready;
   assign req_op   = slot_alloc_pkg::opcode_type'(req_chan.opcode);

   assign rd_owner = rd_entry[ENTRY_W-1:TIME_W];
   assign rd_stamp = rd_entry[TIME_W-1:0];
   assign wr_entry = {id_counter_ff, time_now_ff};

   assign slot_ext = {{IDX_W{1'b0}}, pend_idx_ff};
   assign gid_ext  = {{GID_W{1'b0}}, id_counter_ff};
   assign rid_ext  = {{ID_BITS{1'b0}}, req_chan.release_id};

   assign cur_busy  = busy_ff[pend_idx_ff];
   assign age       = time_now_ff - rd_stamp;
   assign timed_out = age > {{(TIME_W-AGE_W){1'b0}}, max_age_ff};
   assign hit       = pend_ff && ((op_ff == slot_alloc_pkg::OP_ALLOC)
                                  ? (!cur_busy || timed_out)
                                  : (cur_busy && rd_owner == rid_ff));
   assign scan_done = pend_ff && (hit || pend_last_ff);
   assign issue     = iss_cnt_ff != SCAN_LEN;

   slot_alloc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (pend_idx_ff),
      .wr_data (wr_entry),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_entry)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         slot_alloc_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_op inside {slot_alloc_pkg::OP_ALLOC, slot_alloc_pkg::OP_RELEASE}) begin
                  state_in = slot_alloc_pkg::ST_SCAN;
               end else begin
                  state_in = slot_alloc_pkg::ST_RESP;
               end
            end
         end
         slot_alloc_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = slot_alloc_pkg::ST_RESP;
            end
         end
         slot_alloc_pkg::ST_RESP: begin
            if (rsp_fire) begin
               state_in = slot_alloc_pkg::ST_IDLE;
            end
         end
         default: state_in = slot_alloc_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      busy_in         = busy_ff;
      time_now_in     = time_now_ff;
      id_counter_in   = id_counter_ff;
      search_start_in = search_start_ff;
      max_age_in      = max_age_ff;
      op_in           = op_ff;
      rid_in          = rid_ff;
      scan_idx_in     = scan_idx_ff;
      iss_cnt_in      = iss_cnt_ff;
      pend_in         = pend_ff;
      pend_idx_in     = pend_idx_ff;
      pend_last_in    = pend_last_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_id_in       = rsp_id_ff;
      rsp_recl_in     = rsp_recl_ff;
      ram_we          = 1'b0;

      if (csr_fire) begin
         max_age_in = csr_chan.data;
      end

      case (state_ff)
         slot_alloc_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in         = req_op;
               rid_in        = rid_ext[ID_BITS-1:0];
               scan_idx_in   = (req_op == slot_alloc_pkg::OP_ALLOC) ? search_start_ff : '0;
               iss_cnt_in    = '0;
               pend_in       = 1'b0;
               rsp_status_in = slot_alloc_pkg::STAT_DONE;
               rsp_slot_in   = '0;
               rsp_id_in     = '0;
               rsp_recl_in   = 1'b0;
               if (req_op == slot_alloc_pkg::OP_TICK) begin
                  time_now_in = time_now_ff + TIME_W'(1);
               end
            end
         end
         slot_alloc_pkg::ST_SCAN: begin
            if (!scan_done) begin
               if (issue) begin
                  scan_idx_in = (scan_idx_ff == LAST_SLOT) ? '0 : scan_idx_ff + SLOT_BITS'(1);
                  iss_cnt_in  = iss_cnt_ff + CNT_BITS'(1);
               end
               pend_in      = issue;
               pend_idx_in  = scan_idx_ff;
               pend_last_in = iss_cnt_ff == SCAN_LAST;
            end
            if (hit) begin
               rsp_status_in = slot_alloc_pkg::STAT_DONE;
               rsp_slot_in   = slot_ext[IDX_W-1:0];
               if (op_ff == slot_alloc_pkg::OP_ALLOC) begin
                  ram_we                 = 1'b1;
                  busy_in[pend_idx_ff]   = 1'b1;
                  id_counter_in          = id_counter_ff + ID_BITS'(1);
                  search_start_in        = pend_idx_ff;
                  rsp_id_in              = gid_ext[GID_W-1:0];
                  rsp_recl_in            = cur_busy;
               end else begin
                  busy_in[pend_idx_ff]   = 1'b0;
                  rsp_id_in              = '0;
                  rsp_recl_in            = 1'b0;
               end
            end else if (scan_done) begin
               rsp_status_in = (op_ff == slot_alloc_pkg::OP_ALLOC) ?
                               slot_alloc_pkg::STAT_NO_SLOT : slot_alloc_pkg::STAT_NOT_FOUND;
               rsp_slot_in   = '0;
               rsp_id_in     = '0;
               rsp_recl_in   = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= slot_alloc_pkg::ST_IDLE;
         busy_ff         <= '0;
         time_now_ff     <= '0;
         id_counter_ff   <= '0;
         search_start_ff <= '0;
         max_age_ff      <= slot_alloc_pkg::MAX_AGE_RST;
         iss_cnt_ff      <= '0;
         pend_ff         <= 1'b0;
      end else begin
         state_ff        <= state_in;
         busy_ff         <= busy_in;
         time_now_ff     <= time_now_in;
         id_counter_ff   <= id_counter_in;
         search_start_ff <= search_start_in;
         max_age_ff      <= max_age_in;
         iss_cnt_ff      <= iss_cnt_in;
         pend_ff         <= pend_in;
      end
      op_ff         <= op_in;
      rid_ff        <= rid_in;
      scan_idx_ff   <= scan_idx_in;
      pend_idx_ff   <= pend_idx_in;
      pend_last_ff  <= pend_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_recl_ff   <= rsp_recl_in;
   end

   assign req_chan.ready      = state_ff == slot_alloc_pkg::ST_IDLE;
   assign csr_chan.ready      = 1'b1;
   assign rsp_chan.valid      = state_ff == slot_alloc_pkg::ST_RESP;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.slot_index = rsp_slot_ff;
   assign rsp_chan.granted_id = rsp_id_ff;
   assign rsp_chan.reclaimed  = rsp_recl_ff;

`ifndef SYNTHESIS
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_op == slot_alloc_pkg::OP_ALLOC || req_op == slot_alloc_pkg::OP_RELEASE))
      |=> state_ff == slot_alloc_pkg::ST_SCAN)
      else $error("alloc/release did not start a scan");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == slot_alloc_pkg::ST_SCAN |-> iss_cnt_ff <= SCAN_LEN)
      else $error("scan issued past the table");

   a_grant_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == slot_alloc_pkg::ST_RESP && op_ff == slot_alloc_pkg::OP_ALLOC &&
       rsp_status_ff == slot_alloc_pkg::STAT_DONE) |-> busy_ff[pend_idx_ff])
      else $error("granted slot not marked busy");

   a_time_hold: assert property (@(posedge clock) disable iff (reset)
      !(req_fire && req_op == slot_alloc_pkg::OP_TICK) |=> $stable(time_now_ff))
      else $error("time advanced without a tick");

   a_id_step: assert property (@(posedge clock) disable iff (reset)
      !(hit && op_ff == slot_alloc_pkg::OP_ALLOC) |=> $stable(id_counter_ff))
      else $error("id counter moved without a grant");
`endif

endmodule

// File: design/slot_alloc_ram.sv
// ----------------------------------------------------------------------------
// Slot allocator RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module slot_alloc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: dv/tb_slot_allocator_with_timeout_reclaim_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot allocator testbench
// Sends allocate, release, tick and no-op transactions to the next-fit slot
// allocator and checks every response, field by field, against a local model
// of the slot table or a typed row's response. A short directed table runs
// first, then random phases with their own max_age; pairs share an idle pattern.
// ----------------------------------------------------------------------------
module tb_slot_allocator_with_timeout_reclaim_top;

   localparam int NUM_SLOTS     = slot_alloc_pkg::NUM_SLOTS_DEF;
   localparam int SLOT_IDX_W    = slot_alloc_pkg::SLOT_IDX_W;
   localparam int GRANT_ID_W    = slot_alloc_pkg::GRANT_ID_W;
   localparam int REL_ID_W      = slot_alloc_pkg::REL_ID_W;
   localparam int MAX_AGE_W     = slot_alloc_pkg::MAX_AGE_W;
   localparam int TIME_W        = slot_alloc_pkg::TIME_W;
   localparam int DIRECTED_ROWS = 25;
   localparam int NUM_PHASES    = 6;
   localparam int PHASE_ITEMS   = 325;
   localparam int LONG_STALL    = 250;
   localparam int DRAIN_CYCLES  = NUM_SLOTS + 4;

   typedef struct packed {
      slot_alloc_pkg::status_type status;
      logic [SLOT_IDX_W-1:0]      slot_index;
      logic [GRANT_ID_W-1:0]      granted_id;
      logic                       reclaimed;
   } alloc_rsp_type;

   typedef struct packed {
      slot_alloc_pkg::opcode_type op;
      logic [REL_ID_W-1:0]        release_id;
      logic                       typed;
      alloc_rsp_type              rsp;
   } script_row_type;

   typedef enum int {
      IDLE_SND_LIGHT,
      IDLE_SND_HEAVY,
      IDLE_NONE
   } idle_mode_type;

   localparam alloc_rsp_type RSP_ZERO      =
      '{slot_alloc_pkg::STAT_DONE, 4'd0, 16'd0, 1'b0};
   localparam alloc_rsp_type RSP_NO_SLOT   =
      '{slot_alloc_pkg::STAT_NO_SLOT, 4'd0, 16'd0, 1'b0};
   localparam alloc_rsp_type RSP_NOT_FOUND =
      '{slot_alloc_pkg::STAT_NOT_FOUND, 4'd0, 16'd0, 1'b0};

   localparam logic [MAX_AGE_W-1:0] PHASE_MAX_AGE [NUM_PHASES] =
      '{16'hFFFF, 16'd0, 16'd3, 16'd40, 16'd1000, 16'd1};

   // run with max_age 0: fill the pool, fail, then reclaim after one tick
   script_row_type directed_rows [DIRECTED_ROWS] = '{
      '{slot_alloc_pkg::OP_TICK,    16'h0000, 1'b1, RSP_ZERO},
      '{slot_alloc_pkg::OP_NOP,     16'hFFFF, 1'b1, RSP_ZERO},
      '{slot_alloc_pkg::OP_RELEASE, 16'hFFFF, 1'b1, RSP_NOT_FOUND},
      '{slot_alloc_pkg::OP_ALLOC,   16'h0000, 1'b1,
        '{slot_alloc_pkg::STAT_DONE, 4'd0, 16'd0, 1'b0}},
      '{slot_alloc_pkg::OP_ALLOC,   16'hFFFF, 1'b1,
        '{slot_alloc_pkg::STAT_DONE, 4'd1, 16'd1, 1'b0}},
      '{slot_alloc_pkg::OP_RELEASE, 16'h0000, 1'b1, RSP_ZERO},
      '{slot_alloc_pkg::OP_RELEASE, 16'h0000, 1'b1, RSP_NOT_FOUND},
      '{slot_alloc_pkg::OP_ALLOC,   16'h5A5A, 1'b0, RSP_ZERO},
      '{slot_alloc_pkg::OP_ALLOC,   16'hA5A5, 1'b0, RSP_ZERO},
      '{slot_alloc_pkg::OP_ALLOC,   16'h0000, 1'b0, RSP_ZERO},
      '{slot_alloc_pkg::OP_ALLOC,   16'h0000, 1'b0, RSP_ZERO},
      '{slot_alloc_pkg::OP_ALLOC,   16'h0000, 1'b0, RSP_ZERO},
      '{slot_alloc_pkg::OP_ALLOC,   16'h0000, 1'b0, RSP_ZERO},
      '{slot_alloc_pkg::OP_ALLOC,   16'h0000, 1'b0, RSP_ZERO},
      '{slot_alloc_pkg::OP_ALLOC,   16'h0000, 1'b0, RSP_ZERO},
      '{slot_alloc_pkg::OP_ALLOC,   16'h0000, 1'b0, RSP_ZERO},
      '{slot_alloc_pkg::OP_ALLOC,   16'h0000, 1'b0, RSP_ZERO},
      '{slot_alloc_pkg::OP_ALLOC,   16'h0000, 1'b0, RSP_ZERO},
      '{slot_alloc_pkg::OP_ALLOC,   16'h0000, 1'b0, RSP_ZERO},
      '{slot_alloc_pkg::OP_ALLOC,   16'h0000, 1'b0, RSP_ZERO},
      '{slot_alloc_pkg::OP_ALLOC,   16'h0000, 1'b0, RSP_ZERO},
      '{slot_alloc_pkg::OP_ALLOC,   16'h0000, 1'b0, RSP_ZERO},
      '{slot_alloc_pkg::OP_ALLOC,   16'h0000, 1'b1, RSP_NO_SLOT},
      '{slot_alloc_pkg::OP_TICK,    16'h0000, 1'b1, RSP_ZERO},
      '{slot_alloc_pkg::OP_ALLOC,   16'h0000, 1'b0, RSP_ZERO}
   };

   logic clock = 1'b0;
   logic reset;

   slot_alloc_req_if req_chan ();
   slot_alloc_rsp_if rsp_chan ();
   slot_alloc_csr_if csr_chan ();

   slot_allocator_with_timeout_reclaim_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // slot table model
   logic                  slot_held  [NUM_SLOTS];
   logic [GRANT_ID_W-1:0] holder_id  [NUM_SLOTS];
   logic [TIME_W-1:0]     grant_time [NUM_SLOTS];
   logic [TIME_W-1:0]     tick_count;
   logic [GRANT_ID_W-1:0] id_next;
   logic [SLOT_IDX_W-1:0] scan_origin;
   logic [MAX_AGE_W-1:0]  max_age_model;

   alloc_rsp_type expected_rsp_q [$];
   int            mismatch_count = 0;
   int            snd_idle_pct   = 0;
   int            rcv_idle_pct   = 0;
   int            rsp_stall_len  = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void reset_model();
      int k;
      for (k = 0; k < NUM_SLOTS; k++) begin
         slot_held[k]  = 1'b0;
         holder_id[k]  = '0;
         grant_time[k] = '0;
      end
      tick_count    = '0;
      id_next       = '0;
      scan_origin   = '0;
      max_age_model = slot_alloc_pkg::MAX_AGE_RST;
   endfunction

   function automatic alloc_rsp_type predict_slot_op(input slot_alloc_pkg::opcode_type op,
                                                     input logic [REL_ID_W-1:0] rel_id);
      alloc_rsp_type         r;
      int                    k;
      logic [SLOT_IDX_W-1:0] idx;
      logic [TIME_W-1:0]     age;
      logic                  found;
      r     = RSP_ZERO;
      found = 1'b0;
      case (op)
         slot_alloc_pkg::OP_ALLOC: begin
            for (k = 0; k < NUM_SLOTS; k++) begin
               idx = scan_origin + SLOT_IDX_W'(k);
               age = tick_count - grant_time[idx];
               if (!found && (!slot_held[idx] || age > TIME_W'(max_age_model))) begin
                  found           = 1'b1;
                  r.slot_index    = idx;
                  r.granted_id    = id_next;
                  r.reclaimed     = slot_held[idx];
                  slot_held[idx]  = 1'b1;
                  holder_id[idx]  = id_next;
                  grant_time[idx] = tick_count;
                  id_next         = id_next + GRANT_ID_W'(1);
                  scan_origin     = idx;
               end
            end
            if (!found)
               r = RSP_NO_SLOT;
         end
         slot_alloc_pkg::OP_RELEASE: begin
            for (k = 0; k < NUM_SLOTS; k++) begin
               if (!found && slot_held[k] && holder_id[k] == GRANT_ID_W'(rel_id)) begin
                  found        = 1'b1;
                  slot_held[k] = 1'b0;
                  r.slot_index = SLOT_IDX_W'(k);
               end
            end
            if (!found)
               r = RSP_NOT_FOUND;
         end
         slot_alloc_pkg::OP_TICK: tick_count = tick_count + TIME_W'(1);
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input alloc_rsp_type want,
                                  input alloc_rsp_type seen);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $write("%0t %s: expected status=%0d slot=%0d id=%0d recl=%0d, ",
                $realtime, what, want.status, want.slot_index, want.granted_id,
                want.reclaimed);
         $display("actual status=%0d slot=%0d id=%0d recl=%0d",
                  seen.status, seen.slot_index, seen.granted_id, seen.reclaimed);
      end
   endtask

   task automatic set_idle_mode(input idle_mode_type mode);
      case (mode)
         IDLE_SND_LIGHT: begin
            snd_idle_pct = 18;
            rcv_idle_pct = 79;
         end
         IDLE_SND_HEAVY: begin
            snd_idle_pct = 79;
            rcv_idle_pct = 18;
         end
         default: begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
         end
      endcase
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (expected_rsp_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic send_req(input slot_alloc_pkg::opcode_type op,
                           input logic [REL_ID_W-1:0] rel_id,
                           input logic typed, input alloc_rsp_type typed_rsp);
      alloc_rsp_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid      = 1'b1;
      req_chan.opcode     = op;
      req_chan.release_id = rel_id;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      predicted = predict_slot_op(op, rel_id);
      if (typed)
         predicted = typed_rsp;
      expected_rsp_q = {expected_rsp_q, predicted};
   endtask

   task automatic write_max_age(input logic [MAX_AGE_W-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_chan.valid = 1'b1;
      csr_chan.data  = value;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      max_age_model = value;
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   task automatic random_req();
      int                         pick;
      int                         k;
      int                         held [$];
      logic [REL_ID_W-1:0]        rel_id;
      slot_alloc_pkg::opcode_type op;
      pick   = $urandom_range(99);
      rel_id = REL_ID_W'($urandom);
      if (pick < 40) begin
         op = slot_alloc_pkg::OP_ALLOC;
      end else if (pick < 70) begin
         op = slot_alloc_pkg::OP_RELEASE;
         for (k = 0; k < NUM_SLOTS; k++)
            if (slot_held[k])
               held = {held, k};
         if (held.size() != 0)
            rel_id = REL_ID_W'(holder_id[held[$urandom_range(held.size() - 1)]]);
      end else if (pick < 85) begin
         op = slot_alloc_pkg::OP_TICK;
      end else if (pick < 95) begin
         op = slot_alloc_pkg::OP_RELEASE;
      end else begin
         op = slot_alloc_pkg::OP_NOP;
      end
      send_req(op, rel_id, 1'b0, RSP_ZERO);
   endtask

   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_stall_len != 0) begin
            stall          = rsp_stall_len;
            rsp_stall_len  = 0;
            rsp_chan.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready = ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      alloc_rsp_type seen;
      alloc_rsp_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         seen = '{slot_alloc_pkg::status_type'(rsp_chan.status), rsp_chan.slot_index,
                  rsp_chan.granted_id, rsp_chan.reclaimed};
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("unexpected response", RSP_ZERO, seen);
         end else begin
            want = expected_rsp_q.pop_front();
            if (seen.status !== want.status || seen.slot_index !== want.slot_index ||
                seen.granted_id !== want.granted_id || seen.reclaimed !== want.reclaimed)
               report_mismatch("response", want, seen);
         end
      end
   end

   initial begin
      int p;
      int i;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.opcode     = slot_alloc_pkg::OP_NOP;
      req_chan.release_id = '0;
      csr_chan.valid      = 1'b0;
      csr_chan.data       = '0;
      reset_model();
      repeat (9) @(negedge clock);
      reset = 1'b0;

      set_idle_mode(IDLE_SND_LIGHT);
      write_max_age(16'd0);
      for (i = 0; i < DIRECTED_ROWS; i++)
         send_req(directed_rows[i].op, directed_rows[i].release_id,
                  directed_rows[i].typed, directed_rows[i].rsp);

      for (p = 0; p < NUM_PHASES; p++) begin
         set_idle_mode(idle_mode_type'(p / 2));
         write_max_age(PHASE_MAX_AGE[p]);
         for (i = 0; i < PHASE_ITEMS; i++) begin
            if (i == 60)
               rsp_stall_len = LONG_STALL;
            if (i == 200)
               wait_drained();
            random_req();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp_q.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #100000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
